@@ rtl/bgld_pkg.sv @@
// Shared types, constants and helper functions for the Bayer gradient luma demosaic.
// Used by the front end, the queue, the back end and the top level.
package bgld_pkg;

  localparam int PIX_W = 16;
  localparam int TAPS = 25;
  localparam int DIRS = 8;
  localparam int GRAD_W = 19;
  localparam int SUM_W = 20;
  localparam int CNT_W = 4;
  localparam int CENTRE_TAP = 12;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [1:0] {
    CFG_WIDTH   = 2'd0,
    CFG_HEIGHT  = 2'd1,
    CFG_PATTERN = 2'd2
  } cfg_index_t;

  localparam logic [2:0] CFA_PASS = 3'd0;
  localparam logic [2:0] CFA_RGGB = 3'd1;
  localparam logic [2:0] CFA_BGGR = 3'd2;
  localparam logic [2:0] CFA_GRBG = 3'd3;
  localparam logic [2:0] CFA_GBRG = 3'd4;

  localparam logic [1:0] CH_R = 2'd0;
  localparam logic [1:0] CH_G = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;

  typedef struct packed {
    logic [TAPS-1:0][PIX_W-1:0] taps;
    logic [2:0]                 pattern;
    logic                       row_odd;
    logic                       col_odd;
    logic                       frame_end;
  } task_t;

  localparam logic [4:0] GRAD_TAP [DIRS][8] = '{
    '{5'd2,  5'd12, 5'd7,  5'd17, 5'd6,  5'd16, 5'd8,  5'd18},
    '{5'd22, 5'd12, 5'd17, 5'd7,  5'd16, 5'd6,  5'd18, 5'd8},
    '{5'd14, 5'd12, 5'd13, 5'd11, 5'd8,  5'd6,  5'd18, 5'd16},
    '{5'd10, 5'd12, 5'd11, 5'd13, 5'd6,  5'd8,  5'd16, 5'd18},
    '{5'd4,  5'd12, 5'd8,  5'd16, 5'd7,  5'd11, 5'd13, 5'd17},
    '{5'd0,  5'd12, 5'd6,  5'd18, 5'd7,  5'd13, 5'd11, 5'd17},
    '{5'd24, 5'd12, 5'd18, 5'd6,  5'd17, 5'd13, 5'd11, 5'd7},
    '{5'd20, 5'd12, 5'd16, 5'd8,  5'd17, 5'd11, 5'd13, 5'd7}
  };

  localparam logic [4:0] NB_TAP [DIRS] = '{
    5'd7, 5'd17, 5'd13, 5'd11, 5'd8, 5'd6, 5'd18, 5'd16
  };
  localparam logic NB_ROW_ODD [DIRS] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
  localparam logic NB_COL_ODD [DIRS] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

  localparam logic [15:0] WEIGHT [3] = '{16'd13933, 16'd46871, 16'd4732};

  function automatic pix_t absdiff(pix_t a, pix_t b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [1:0] chan_of(logic [2:0] pattern, logic row_odd, logic col_odd);
    logic [1:0] site;
    site = {row_odd, col_odd};
    chan_of = CH_G;
    case (pattern)
      CFA_RGGB: chan_of = (site == 2'd0) ? CH_R : (site == 2'd3) ? CH_B : CH_G;
      CFA_BGGR: chan_of = (site == 2'd0) ? CH_B : (site == 2'd3) ? CH_R : CH_G;
      CFA_GRBG: chan_of = (site == 2'd1) ? CH_R : (site == 2'd2) ? CH_B : CH_G;
      CFA_GBRG: chan_of = (site == 2'd1) ? CH_B : (site == 2'd2) ? CH_R : CH_G;
      default:  chan_of = CH_G;
    endcase
  endfunction

endpackage

@@ rtl/bgld_if.sv @@
// Stream interfaces for raw pixel words in and luma words out.
// No dependencies.
interface bgld_pixel_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] raw_pixel;
  modport source(output valid, output operation, output raw_pixel, input ready);
  modport sink(input valid, input operation, input raw_pixel, output ready);
endinterface

interface bgld_luma_if;
  logic        valid;
  logic        ready;
  logic [15:0] luma;
  logic        frame_end;
  modport source(output valid, output luma, output frame_end, input ready);
  modport sink(input valid, input luma, input frame_end, output ready);
endinterface

@@ rtl/bgld_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bgld_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/bgld_front.sv @@
// Front end: accepts raw pixel words, runs the line stores and the 5x5 window,
// and hands masked windows to the queue. Depends on bgld_pkg, bgld_if, bgld_ram.
module bgld_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   width,
  input  logic [15:0]                      height,
  input  logic [2:0]                       pattern,
  bgld_pixel_if.sink                       pixel_in,
  output bgld_pkg::task_t                  push_task,
  output logic                             push_valid,
  input  logic                             push_ready
);
  import bgld_pkg::*;

  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int COLB = $clog2(MAX_WIDTH);
  localparam int CW = WB + 2;
  localparam pix_t PIX_MASK = pix_t'((32'd1 << PIXEL_BITS) - 32'd1);

  typedef enum logic [1:0] {F_IDLE, F_LOAD, F_EMIT} fstate_t;

  fstate_t           state;
  logic [COLB-1:0]   in_column;
  logic [23:0]       in_row;
  logic [COLB-1:0]   centre_column;
  logic [15:0]       centre_row;
  pix_t              sample;
  logic              due;
  logic [COLB-1:0]   wr_addr;
  pix_t              win [5][5];

  logic              accept;
  logic              ahead_ok;
  logic [CW-1:0]     ic_inc;
  logic [CW-1:0]     cc_inc;
  logic              frame_last;
  logic [4*PIX_W-1:0] rd_data;
  pix_t              col_new [5];
  logic [4:0]        row_ok;
  logic [4:0]        col_ok;
  logic [16:0]       trow [5];
  logic [CW-1:0]     tcol [5];

  assign pixel_in.ready = (state == F_IDLE);
  assign accept = pixel_in.valid && (state == F_IDLE);
  assign push_valid = (state == F_EMIT);

  bgld_ram #(.WIDTH(4 * PIX_W), .DEPTH(MAX_WIDTH)) u_lines (
    .clk     (clk),
    .wr_en   (state == F_LOAD),
    .wr_addr (wr_addr),
    .wr_data ({rd_data[3*PIX_W-1:0], sample}),
    .rd_en   (accept),
    .rd_addr (in_column),
    .rd_data (rd_data)
  );

  always_comb begin
    ic_inc = CW'(in_column) + CW'(1);
    cc_inc = CW'(centre_column) + CW'(1);
    if (width == WB'(1)) begin
      ahead_ok = (in_row >= 24'd4);
    end else begin
      ahead_ok = (in_row >= 24'd3) || ((in_row == 24'd2) && (in_column >= COLB'(2)));
    end
    frame_last = (centre_row >= (height - 16'd1)) && (cc_inc >= CW'(width));
    col_new[0] = rd_data[4*PIX_W-1:3*PIX_W];
    col_new[1] = rd_data[3*PIX_W-1:2*PIX_W];
    col_new[2] = rd_data[2*PIX_W-1:PIX_W];
    col_new[3] = rd_data[PIX_W-1:0];
    col_new[4] = sample;
    for (int r = 0; r < 5; r++) begin
      trow[r] = 17'(centre_row) + 17'(r);
      row_ok[r] = (trow[r] >= 17'd2) && ((trow[r] - 17'd2) < 17'(height));
    end
    for (int c = 0; c < 5; c++) begin
      tcol[c] = CW'(centre_column) + CW'(c);
      col_ok[c] = (tcol[c] >= CW'(2)) && ((tcol[c] - CW'(2)) < CW'(width));
    end
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        push_task.taps[r*5+c] = (row_ok[r] && col_ok[c]) ? win[r][c] : '0;
      end
    end
    push_task.pattern = pattern;
    push_task.row_odd = centre_row[0];
    push_task.col_odd = centre_column[0];
    push_task.frame_end = frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      in_column <= '0;
      in_row <= '0;
      centre_column <= '0;
      centre_row <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            if (ic_inc >= CW'(width)) begin
              in_column <= '0;
              if (in_row != 24'hFFFFFF) begin
                in_row <= in_row + 24'd1;
              end
            end else begin
              in_column <= COLB'(ic_inc);
            end
            state <= F_LOAD;
          end
        end
        F_LOAD: begin
          state <= due ? F_EMIT : F_IDLE;
        end
        F_EMIT: begin
          if (push_ready) begin
            if (frame_last) begin
              in_column <= '0;
              in_row <= '0;
              centre_column <= '0;
              centre_row <= '0;
            end else if (cc_inc >= CW'(width)) begin
              centre_column <= '0;
              centre_row <= centre_row + 16'd1;
            end else begin
              centre_column <= COLB'(cc_inc);
            end
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= pixel_in.operation ? '0 : (pixel_in.raw_pixel & PIX_MASK);
      due <= ahead_ok;
      wr_addr <= in_column;
    end
    if (state == F_LOAD) begin
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 4; c++) begin
          win[r][c] <= win[r][c+1];
        end
        win[r][4] <= col_new[r];
      end
    end
  end

endmodule

@@ rtl/bgld_queue.sv @@
// Two-entry queue of windows between the front end and the back end.
// Depends on bgld_pkg.
module bgld_queue (
  input  logic            clk,
  input  logic            rst,
  input  bgld_pkg::task_t push_task,
  input  logic            push_valid,
  output logic            push_ready,
  output bgld_pkg::task_t pop_task,
  output logic            pop_valid,
  input  logic            pop_ready
);
  import bgld_pkg::*;

  task_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid = (fill != 2'd0);
  assign pop_task = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_task;
    end
  end

endmodule

@@ rtl/bgld_back.sv @@
// Back end: gradients, threshold, channel sums, shared divider and luma multiply.
// Depends on bgld_pkg and bgld_if.
module bgld_back (
  input  logic            clk,
  input  logic            rst,
  input  bgld_pkg::task_t pop_task,
  input  logic            pop_valid,
  output logic            pop_ready,
  bgld_luma_if.source     luma_out
);
  import bgld_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_GRAD, B_RANGE, B_SUM, B_DIV, B_MUL, B_LUMA, B_OUT}
    bstate_t;

  bstate_t           state;
  task_t             job;
  logic [GRAD_W-1:0] grad [DIRS];
  logic [GRAD_W-1:0] gmin;
  logic [GRAD_W-1:0] gmax;
  logic [SUM_W-1:0]  sum [3];
  logic [CNT_W-1:0]  cnt [3];
  pix_t              avg [3];
  logic [1:0]        ch;
  logic              div_busy;
  logic [SUM_W-1:0]  div_n;
  logic [4:0]        div_rem;
  logic [4:0]        div_step;
  logic [1:0]        mul_idx;
  logic [32:0]       acc;
  pix_t              out_luma;
  logic              out_end;

  logic [GRAD_W-1:0] grad_c [DIRS];
  logic [GRAD_W-1:0] gmin_c;
  logic [GRAD_W-1:0] gmax_c;
  logic [SUM_W-1:0]  sum_c [3];
  logic [CNT_W-1:0]  cnt_c [3];
  logic [20:0]       thr;
  logic [1:0]        nb_ch [DIRS];
  logic [1:0]        centre_ch;
  logic [5:0]        trial;
  logic              trial_ok;
  logic [31:0]       prod;
  pix_t              centre;

  assign pop_ready = (state == B_IDLE);
  assign luma_out.valid = (state == B_OUT);
  assign luma_out.luma = out_luma;
  assign luma_out.frame_end = out_end;
  assign centre = job.taps[CENTRE_TAP];

  always_comb begin
    for (int i = 0; i < DIRS; i++) begin
      grad_c[i] = {2'b0, absdiff(job.taps[GRAD_TAP[i][0]], job.taps[GRAD_TAP[i][1]]), 1'b0}
                + GRAD_W'(absdiff(job.taps[GRAD_TAP[i][2]], job.taps[GRAD_TAP[i][3]]))
                + GRAD_W'(absdiff(job.taps[GRAD_TAP[i][4]], job.taps[GRAD_TAP[i][5]]))
                + GRAD_W'(absdiff(job.taps[GRAD_TAP[i][6]], job.taps[GRAD_TAP[i][7]]));
    end
    gmin_c = grad[0];
    gmax_c = grad[0];
    for (int i = 1; i < DIRS; i++) begin
      if (grad[i] < gmin_c) gmin_c = grad[i];
      if (grad[i] > gmax_c) gmax_c = grad[i];
    end
    thr = {1'b0, gmin, 1'b0} + {2'b0, gmax};
    for (int i = 0; i < DIRS; i++) begin
      nb_ch[i] = chan_of(job.pattern, job.row_odd ^ NB_ROW_ODD[i], job.col_odd ^ NB_COL_ODD[i]);
    end
    centre_ch = chan_of(job.pattern, job.row_odd, job.col_odd);
    for (int k = 0; k < 3; k++) begin
      sum_c[k] = (centre_ch == 2'(k)) ? SUM_W'(centre) : '0;
      cnt_c[k] = (centre_ch == 2'(k)) ? CNT_W'(1) : '0;
      for (int i = 0; i < DIRS; i++) begin
        if (({1'b0, grad[i], 1'b0} <= thr) && (nb_ch[i] == 2'(k))) begin
          sum_c[k] = sum_c[k] + SUM_W'(job.taps[NB_TAP[i]]);
          cnt_c[k] = cnt_c[k] + CNT_W'(1);
        end
      end
    end
    trial = {div_rem, div_n[SUM_W-1]};
    trial_ok = (trial >= {2'b0, cnt[ch]});
    prod = WEIGHT[mul_idx] * avg[mul_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      div_busy <= 1'b0;
      ch <= 2'd0;
      mul_idx <= 2'd0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (pop_valid) begin
            job <= pop_task;
            out_end <= pop_task.frame_end;
            if (pop_task.pattern == CFA_PASS) begin
              out_luma <= pop_task.taps[CENTRE_TAP];
              state <= B_OUT;
            end else begin
              state <= B_GRAD;
            end
          end
        end
        B_GRAD: begin
          grad <= grad_c;
          state <= B_RANGE;
        end
        B_RANGE: begin
          gmin <= gmin_c;
          gmax <= gmax_c;
          state <= B_SUM;
        end
        B_SUM: begin
          sum <= sum_c;
          cnt <= cnt_c;
          ch <= 2'd0;
          div_busy <= 1'b0;
          state <= B_DIV;
        end
        B_DIV: begin
          if (!div_busy) begin
            if (cnt[ch] == '0) begin
              avg[ch] <= centre;
              if (ch == 2'd2) begin
                mul_idx <= 2'd0;
                acc <= 33'd32768;
                state <= B_MUL;
              end else begin
                ch <= ch + 2'd1;
              end
            end else begin
              div_n <= sum[ch] + SUM_W'(cnt[ch] >> 1);
              div_rem <= '0;
              div_step <= '0;
              div_busy <= 1'b1;
            end
          end else begin
            div_rem <= trial_ok ? 5'(trial - {2'b0, cnt[ch]}) : trial[4:0];
            div_n <= {div_n[SUM_W-2:0], trial_ok};
            div_step <= div_step + 5'd1;
            if (div_step == 5'(SUM_W - 1)) begin
              avg[ch] <= {div_n[PIX_W-2:0], trial_ok};
              div_busy <= 1'b0;
              if (ch == 2'd2) begin
                mul_idx <= 2'd0;
                acc <= 33'd32768;
                state <= B_MUL;
              end else begin
                ch <= ch + 2'd1;
              end
            end
          end
        end
        B_MUL: begin
          acc <= acc + 33'(prod);
          if (mul_idx == 2'd2) begin
            state <= B_LUMA;
          end else begin
            mul_idx <= mul_idx + 2'd1;
          end
        end
        B_LUMA: begin
          out_luma <= acc[32] ? 16'hFFFF : acc[31:16];
          state <= B_OUT;
        end
        B_OUT: begin
          if (luma_out.ready) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/bayer_gradient_luma_demosaic.sv @@
// Top level of the Bayer gradient luma demosaic: configuration registers and the
// front end, window queue and back end. Depends on bgld_pkg, bgld_if and submodules.
//
//   channel     kind          words
//   pixel_in    stream sink   operation, raw_pixel
//   luma_out    stream source luma, frame_end
//   cfg_*       write port    cfg_index, cfg_data
//
// The front end takes a pixel word only while idle and loads it into the line store and
// window; a word that completes a window has it emitted to the queue before the next word.
// The back end takes one window at a time; each color channel whose count is nonzero goes
// through its single shared bit-serial divider. Pass-through pattern results bypass it.
// Synchronous reset clears control state only; the line store RAM needs no clearing.
// A two-window queue and the output register let either side stall independently.
module bayer_gradient_luma_demosaic #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  bgld_pixel_if.sink  pixel_in,
  bgld_luma_if.source luma_out
);
  import bgld_pkg::*;

  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = ((WB > 13) ? WB : 13) + 1;

  logic [12:0]   frame_width;
  logic [15:0]   frame_height;
  logic [2:0]    cfa_pattern;
  logic [WB-1:0] width_eff;
  logic [15:0]   height_eff;

  task_t push_task;
  logic  push_valid;
  logic  push_ready;
  task_t pop_task;
  logic  pop_valid;
  logic  pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 13'd4096;
      frame_height <= 16'd1;
      cfa_pattern <= CFA_PASS;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_WIDTH:   frame_width <= cfg_data[12:0];
        CFG_HEIGHT:  frame_height <= cfg_data;
        CFG_PATTERN: cfa_pattern <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == 13'd0) begin
      width_eff = WB'(1);
    end else if (CMPW'(frame_width) > CMPW'(MAX_WIDTH)) begin
      width_eff = WB'(MAX_WIDTH);
    end else begin
      width_eff = WB'(frame_width);
    end
    height_eff = (frame_height == 16'd0) ? 16'd1 : frame_height;
  end

  bgld_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .width      (width_eff),
    .height     (height_eff),
    .pattern    (cfa_pattern),
    .pixel_in   (pixel_in),
    .push_task  (push_task),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  bgld_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_task  (push_task),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_task   (pop_task),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  bgld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_task  (pop_task),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .luma_out  (luma_out)
  );

endmodule
